### src/dtw_pkg.sv
`timescale 1ns / 1ps

package dtw_pkg;

   localparam int MAX_REF_LEN = 64;
   localparam int SAMPLE_BITS = 16;
   localparam int IDX_W       = $clog2(MAX_REF_LEN);
   localparam int LEN_W       = IDX_W + 1;
   localparam int QRY_LEN_W   = 16;
   localparam int DIST_W      = 48;
   localparam int COST_W      = 2 * SAMPLE_BITS;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   localparam logic [LEN_W-1:0]     REF_LEN_RESET = LEN_W'(64);
   localparam logic [QRY_LEN_W-1:0] QRY_LEN_RESET = QRY_LEN_W'(64);

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_REF_LENGTH   = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_QUERY_LENGTH = CSR_INDEX_W'(1);

   // request function codes
   localparam logic FUNC_LOAD_REF = 1'b0;
   localparam logic FUNC_QUERY    = 1'b1;

   typedef struct packed {
      logic             load_ref;
      logic [IDX_W-1:0] ref_addr;
      logic             capture;
      logic             first;
      logic             issue;
      logic [IDX_W-1:0] rd_addr;
      logic             emit;
   } dtw_cmd_type;

   typedef struct packed {
      logic rsp_busy;
   } dtw_status_type;

endpackage

### src/dtw_ifs.sv
`timescale 1ns / 1ps

interface dtw_req_if;
   import dtw_pkg::*;
   logic                          valid;
   logic                          ready;
   logic                          func;
   logic signed [SAMPLE_BITS-1:0] sample;
   modport source (output valid, func, sample, input ready);
   modport sink (input valid, func, sample, output ready);
endinterface

interface dtw_rsp_if;
   import dtw_pkg::*;
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] distance;
   logic              saturated;
   modport source (output valid, distance, saturated, input ready);
   modport sink (input valid, distance, saturated, output ready);
endinterface

interface dtw_csr_if;
   import dtw_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### src/dtw_distance_engine_unit.sv
`timescale 1ns / 1ps

// channel   dir  handshake      payload
// req_chan  in   valid / ready  func, sample
// rsp_chan  out  valid / ready  distance, saturated
// csr_chan  in   valid / ready  index, data
//
// a reference load request writes one sample and leaves the engine idle; a query request
// steps through n cells, n being the reference length in use, one cell per cycle through the
// shared cost pipeline (read, square, min and add)
// reset clears control state only; stored reference and cost row are undefined
// a finished result waits in the output register while the next request is taken;
// only the final query of a comparison stalls, until that register is free

module dtw_distance_engine_unit
   import dtw_pkg::*;
(
   input logic       clock,
   input logic       reset,
   dtw_req_if.sink   req_chan,
   dtw_rsp_if.source rsp_chan,
   dtw_csr_if.sink   csr_chan
);

   dtw_cmd_type    cmd;
   dtw_status_type status;

   dtw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_func  (req_chan.func),
      .req_ready (req_chan.ready),
      .csr_valid (csr_chan.valid),
      .csr_index (csr_chan.index),
      .csr_data  (csr_chan.data),
      .csr_ready (csr_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   dtw_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_sample    (req_chan.sample),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_distance  (rsp_chan.distance),
      .rsp_saturated (rsp_chan.saturated)
   );

endmodule

### src/dtw_ctrl.sv
`timescale 1ns / 1ps

module dtw_ctrl
   import dtw_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_func,
   output logic                   req_ready,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic                   csr_ready,
   input  dtw_status_type         status,
   output dtw_cmd_type            cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // stages between cell issue and the cost write
   localparam logic [LEN_W-1:0] DRAIN_LAST = LEN_W'(1);

   state_type            state_ff;
   logic [LEN_W-1:0]     ref_len_ff;
   logic [QRY_LEN_W-1:0] qry_len_ff;
   logic [IDX_W-1:0]     widx_ff;
   logic [QRY_LEN_W-1:0] qidx_ff;
   logic [LEN_W-1:0]     cnt_ff;
   logic [LEN_W-1:0]     n_ff;
   logic                 last_ff;

   logic [LEN_W-1:0]     n_eff;
   logic [QRY_LEN_W-1:0] qlen_eff;
   logic [LEN_W-1:0]     widx_inc;
   logic [IDX_W-1:0]     widx_in;
   logic [QRY_LEN_W:0]   qidx_inc;
   logic                 req_fire;

   always_comb begin
      if (ref_len_ff == '0) begin
         n_eff = LEN_W'(1);
      end else if (ref_len_ff > LEN_W'(MAX_REF_LEN)) begin
         n_eff = LEN_W'(MAX_REF_LEN);
      end else begin
         n_eff = ref_len_ff;
      end
      qlen_eff = (qry_len_ff == '0) ? QRY_LEN_W'(1) : qry_len_ff;
      widx_inc = {1'b0, widx_ff} + LEN_W'(1);
      widx_in  = (widx_inc >= n_eff) ? '0 : widx_inc[IDX_W-1:0];
      qidx_inc = {1'b0, qidx_ff} + (QRY_LEN_W + 1)'(1);
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      cmd.load_ref = req_fire && (req_func == FUNC_LOAD_REF);
      cmd.ref_addr = widx_ff;
      cmd.capture  = req_fire && (req_func == FUNC_QUERY);
      cmd.first    = (qidx_ff == '0);
      cmd.issue    = (state_ff == ST_RUN);
      cmd.rd_addr  = cnt_ff[IDX_W-1:0];
      cmd.emit     = (state_ff == ST_DONE) && last_ff && !status.rsp_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         ref_len_ff <= REF_LEN_RESET;
         qry_len_ff <= QRY_LEN_RESET;
         widx_ff    <= '0;
         qidx_ff    <= '0;
         cnt_ff     <= '0;
         n_ff       <= LEN_W'(1);
         last_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_REF_LENGTH:   ref_len_ff <= csr_data[LEN_W-1:0];
               CSR_QUERY_LENGTH: qry_len_ff <= csr_data[QRY_LEN_W-1:0];
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  if (req_func == FUNC_LOAD_REF) begin
                     widx_ff <= widx_in;
                  end else begin
                     n_ff     <= n_eff;
                     last_ff  <= (qidx_inc >= {1'b0, qlen_eff});
                     cnt_ff   <= '0;
                     state_ff <= ST_RUN;
                  end
               end
            end
            ST_RUN: begin
               if (cnt_ff == n_ff - LEN_W'(1)) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_DRAIN;
               end else begin
                  cnt_ff <= cnt_ff + LEN_W'(1);
               end
            end
            ST_DRAIN: begin
               if (cnt_ff == DRAIN_LAST) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_DONE;
               end else begin
                  cnt_ff <= cnt_ff + LEN_W'(1);
               end
            end
            ST_DONE: begin
               if (!last_ff) begin
                  qidx_ff  <= qidx_inc[QRY_LEN_W-1:0];
                  state_ff <= ST_IDLE;
               end else if (!status.rsp_busy) begin
                  qidx_ff  <= '0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

### src/dtw_dpath.sv
`timescale 1ns / 1ps

module dtw_dpath
   import dtw_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  dtw_cmd_type                   cmd,
   output dtw_status_type                status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [DIST_W-1:0]             rsp_distance,
   output logic                          rsp_saturated
);

   logic [SAMPLE_BITS-1:0] ref_mem [MAX_REF_LEN];
   logic [DIST_W-1:0]      cost_mem [MAX_REF_LEN];

   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic                          first_ff;

   // read stage
   logic                          rd_valid_ff;
   logic [IDX_W-1:0]              rd_addr_ff;
   logic signed [SAMPLE_BITS-1:0] ref_q_ff;
   logic [DIST_W-1:0]             up_q_ff;

   // local cost stage
   logic                          lc_valid_ff;
   logic [IDX_W-1:0]              lc_addr_ff;
   logic [COST_W-1:0]             lc_cost_ff;
   logic [DIST_W-1:0]             lc_up_ff;

   // recurrence
   logic [DIST_W-1:0]             left_ff;
   logic [DIST_W-1:0]             diag_ff;
   logic                          sat_ff;

   logic                          rsp_valid_ff;
   logic [DIST_W-1:0]             rsp_dist_ff;
   logic                          rsp_sat_ff;

   logic signed [SAMPLE_BITS:0]   diff;
   logic [SAMPLE_BITS-1:0]        mag;
   logic [COST_W-1:0]             cost_in;
   logic [DIST_W-1:0]             best;
   logic [DIST_W:0]               sum;
   logic                          sat_hit;
   logic [DIST_W-1:0]             cell_in;

   always_comb begin
      diff    = {x_ff[SAMPLE_BITS-1], x_ff} - {ref_q_ff[SAMPLE_BITS-1], ref_q_ff};
      mag     = diff[SAMPLE_BITS] ? SAMPLE_BITS'(-diff) : diff[SAMPLE_BITS-1:0];
      cost_in = COST_W'(mag) * COST_W'(mag);
   end

   always_comb begin
      if (lc_addr_ff == '0) begin
         best = first_ff ? '0 : lc_up_ff;
      end else if (first_ff) begin
         best = left_ff;
      end else begin
         best = lc_up_ff;
         if (left_ff < best) begin
            best = left_ff;
         end
         if (diag_ff < best) begin
            best = diag_ff;
         end
      end
      sum     = {1'b0, best} + (DIST_W + 1)'(lc_cost_ff);
      sat_hit = (sum >= {1'b0, DIST_MAX});
      cell_in = sat_hit ? DIST_MAX : sum[DIST_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_ref) begin
         ref_mem[cmd.ref_addr] <= req_sample;
      end
      if (cmd.issue) begin
         ref_q_ff <= ref_mem[cmd.rd_addr];
         up_q_ff  <= cost_mem[cmd.rd_addr];
      end
      if (lc_valid_ff) begin
         cost_mem[lc_addr_ff] <= cell_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff     <= req_sample;
         first_ff <= cmd.first;
      end
      rd_addr_ff <= cmd.rd_addr;
      lc_addr_ff <= rd_addr_ff;
      lc_cost_ff <= cost_in;
      lc_up_ff   <= up_q_ff;
      if (lc_valid_ff) begin
         left_ff <= cell_in;
         diag_ff <= lc_up_ff;
      end
      if (cmd.emit) begin
         rsp_dist_ff <= left_ff;
         rsp_sat_ff  <= sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         lc_valid_ff  <= 1'b0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.issue;
         lc_valid_ff <= rd_valid_ff;
         if (cmd.emit) begin
            sat_ff <= 1'b0;
         end else if (lc_valid_ff && sat_hit) begin
            sat_ff <= 1'b1;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_distance    = rsp_dist_ff;
   assign rsp_saturated   = rsp_sat_ff;

endmodule
